FILE: src/ple_pkg.sv
// ple_pkg: request and status codes for the positional list engine.
// Has no dependencies. The engine reads it through scoped names.
`default_nettype none

package ple_pkg;

	typedef logic [2:0] req_t;
	typedef logic [1:0] status_t;

	localparam req_t REQ_INSERT = 3'd0;
	localparam req_t REQ_DELETE = 3'd1;
	localparam req_t REQ_COUNT  = 3'd2;
	localparam req_t REQ_MINMAX = 3'd3;
	localparam req_t REQ_EVEN   = 3'd4;
	localparam req_t REQ_CLEAR  = 3'd5;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_POS   = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;
	localparam status_t STAT_EMPTY = 2'd3;

	// largest value the 7-bit count outputs can show
	localparam logic [6:0] CNT_MAX = 7'd127;

endpackage

`default_nettype wire

FILE: src/positional_list_engine.sv
// positional_list_engine: ordered list of signed words kept in one synchronous RAM.
// Uses ple_pkg for the request and status codes.
//
// Usage:
// Requests come in on in_valid/in_stall with req_type, position and value.
// Each request gives exactly one result on out_valid/out_stall: status,
// match_count, max_value, min_value and list_length. Unused result fields are 0.
// The engine handles one request at a time. in_stall stays high from accept
// until the result is loaded into the output register. The next request may be
// accepted while that result is still waiting to be taken.
// The walk covers length - position entries for insert, length - position - 1
// for delete, the length for count and min/max, half the length for delete-even.
// Clear, unknown and rejected requests do not walk. The result is shown in the
// same cycle in which the next request can be accepted. The RAM has one read
// port and one write port, so the walk steps one entry per cycle, reading one
// entry and, for insert, delete and delete-even, writing back the one before.
// If out_stall holds a result, the next finished result waits in the engine and
// input stays stalled. Reset empties the list. RAM contents are not cleared:
// only entries below the length are ever read.
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic [6:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [6:0]              match_count,
	output logic signed [31:0]      max_value,
	output logic signed [31:0]      min_value,
	output logic [6:0]              list_length
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

	logic [1:0]                   state_q;
	logic                         out_valid_q;
	logic [LW-1:0]                len_q;
	logic [LW-1:0]                rem_q;
	logic                         vld_s1;
	logic [AW-1:0]                wr_s1;
	logic signed [DATA_WIDTH-1:0] rdata_s1;

	ple_pkg::req_t                op_q;
	ple_pkg::status_t             status_q;
	logic [AW-1:0]                raddr_q;
	logic [AW-1:0]                wcnt_q;
	logic [AW-1:0]                pos_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [LW-1:0]                cnt_q;
	logic signed [DATA_WIDTH-1:0] mx_q;
	logic signed [DATA_WIDTH-1:0] mn_q;
	logic                         first_q;

	logic [1:0]                   status_o_q;
	logic [6:0]                   match_o_q;
	logic signed [31:0]           max_o_q;
	logic signed [31:0]           min_o_q;
	logic [6:0]                   length_o_q;

	logic                         accept;
	logic [CW-1:0]                pos_w;
	logic [CW-1:0]                len_w;
	ple_pkg::status_t             acc_status;
	logic [LW-1:0]                acc_rem;
	logic [LW-1:0]                acc_len;
	logic [AW-1:0]                acc_raddr;
	logic                         acc_run;

	logic                         shifting;
	logic                         rd_en;
	logic                         run_end;
	logic                         we;
	logic [AW-1:0]                waddr;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]                raddr_nxt;
	logic [AW-1:0]                wr_nxt;
	logic                         out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign pos_w    = CW'(position);
	assign len_w    = CW'(len_q);

	// request decode: checks, walk length, first read address, new length
	always_comb begin
		acc_status = ple_pkg::STAT_OK;
		acc_rem    = '0;
		acc_len    = len_q;
		acc_raddr  = '0;
		acc_run    = 1'b0;
		case (req_type)
			ple_pkg::REQ_INSERT: begin
				if (pos_w > len_w) begin
					acc_status = ple_pkg::STAT_POS;
				end else if (len_w >= CW'(CAPACITY)) begin
					acc_status = ple_pkg::STAT_FULL;
				end else begin
					acc_run   = 1'b1;
					acc_rem   = LW'(len_w - pos_w);
					acc_raddr = AW'(len_w - CW'(1));
					acc_len   = len_q + LW'(1);
				end
			end
			ple_pkg::REQ_DELETE: begin
				if (len_q == '0) begin
					acc_status = ple_pkg::STAT_EMPTY;
				end else if (pos_w >= len_w) begin
					acc_status = ple_pkg::STAT_POS;
				end else begin
					acc_run   = 1'b1;
					acc_rem   = LW'(len_w - pos_w - CW'(1));
					acc_raddr = AW'(pos_w + CW'(1));
					acc_len   = len_q - LW'(1);
				end
			end
			ple_pkg::REQ_COUNT: begin
				acc_run = 1'b1;
				acc_rem = len_q;
			end
			ple_pkg::REQ_MINMAX: begin
				if (len_q == '0) begin
					acc_status = ple_pkg::STAT_EMPTY;
				end else begin
					acc_run = 1'b1;
					acc_rem = len_q;
				end
			end
			ple_pkg::REQ_EVEN: begin
				// keep odd entries: read 1,3,5.. and pack them to 0,1,2..
				acc_run   = 1'b1;
				acc_rem   = len_q >> 1;
				acc_raddr = AW'(1);
				acc_len   = len_q >> 1;
			end
			ple_pkg::REQ_CLEAR: begin
				acc_len = '0;
			end
			default: begin
			end
		endcase
	end

	assign shifting = (op_q == ple_pkg::REQ_INSERT) || (op_q == ple_pkg::REQ_DELETE) ||
		(op_q == ple_pkg::REQ_EVEN);
	assign rd_en    = (state_q == ST_RUN) && (rem_q != '0);
	assign run_end  = (state_q == ST_RUN) && (rem_q == '0) && !vld_s1;

	// address walk: insert goes down and writes one above, delete goes up and
	// writes one below, delete-even steps by two and writes a packed index
	always_comb begin
		case (op_q)
			ple_pkg::REQ_INSERT: begin
				raddr_nxt = raddr_q - AW'(1);
				wr_nxt    = raddr_q + AW'(1);
			end
			ple_pkg::REQ_DELETE: begin
				raddr_nxt = raddr_q + AW'(1);
				wr_nxt    = raddr_q - AW'(1);
			end
			ple_pkg::REQ_EVEN: begin
				raddr_nxt = raddr_q + AW'(2);
				wr_nxt    = wcnt_q;
			end
			default: begin
				raddr_nxt = raddr_q + AW'(1);
				wr_nxt    = raddr_q;
			end
		endcase
	end

	// write port: shifted entry, or the new value once the insert gap is open
	assign we    = (state_q == ST_RUN) &&
		(vld_s1 ? shifting : ((rem_q == '0) && (op_q == ple_pkg::REQ_INSERT)));
	assign waddr = vld_s1 ? wr_s1 : pos_q;
	assign wdata = vld_s1 ? rdata_s1 : val_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr_q];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			len_q       <= '0;
			rem_q       <= '0;
			vld_s1      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						len_q   <= acc_len;
						rem_q   <= acc_rem;
						state_q <= acc_run ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						rem_q <= rem_q - LW'(1);
					end
					if (run_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req_type;
			status_q <= acc_status;
			raddr_q  <= acc_raddr;
			wcnt_q   <= '0;
			pos_q    <= AW'(position);
			val_q    <= DATA_WIDTH'(value);
			cnt_q    <= '0;
			mx_q     <= '0;
			mn_q     <= '0;
			first_q  <= 1'b1;
		end

		if (rd_en) begin
			raddr_q <= raddr_nxt;
			wr_s1   <= wr_nxt;
			if (op_q == ple_pkg::REQ_EVEN) begin
				wcnt_q <= wcnt_q + AW'(1);
			end
		end

		// scan side of count and min/max
		if ((state_q == ST_RUN) && vld_s1) begin
			if ((op_q == ple_pkg::REQ_COUNT) && (rdata_s1 == val_q)) begin
				cnt_q <= cnt_q + LW'(1);
			end
			if (op_q == ple_pkg::REQ_MINMAX) begin
				first_q <= 1'b0;
				if (first_q || (rdata_s1 > mx_q)) begin
					mx_q <= rdata_s1;
				end
				if (first_q || (rdata_s1 < mn_q)) begin
					mn_q <= rdata_s1;
				end
			end
		end

		if ((state_q == ST_DONE) && out_free) begin
			status_o_q <= status_q;
			match_o_q  <= (cnt_q > LW'(ple_pkg::CNT_MAX)) && (LW > 7) ?
				ple_pkg::CNT_MAX : 7'(cnt_q);
			max_o_q    <= 32'(mx_q);
			min_o_q    <= 32'(mn_q);
			length_o_q <= (len_q > LW'(ple_pkg::CNT_MAX)) && (LW > 7) ?
				ple_pkg::CNT_MAX : 7'(len_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_o_q;
	assign match_count = match_o_q;
	assign max_value   = max_o_q;
	assign min_value   = min_o_q;
	assign list_length = length_o_q;

endmodule

`default_nettype wire
